[design/fct_pkg.sv]
`default_nettype none
package fct_pkg;

  // verdict codes
  localparam logic [1:0] VERDICT_OUT       = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_IN        = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [2:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] REG_PLANE_TOP    = 3'd2;
  localparam logic [2:0] REG_PLANE_BOTTOM = 3'd3;
  localparam logic [2:0] REG_VIEW_DIR     = 3'd4;
  localparam logic [2:0] REG_VIEW_ORIGIN  = 3'd5;
  localparam logic [2:0] REG_MAX_DEPTH    = 3'd6;
  localparam logic [2:0] REG_HOME_SECTOR  = 3'd7;

  localparam int NUM_PLANES = 4;
  localparam int NORM_FRAC  = 10;
  localparam int DIR_FRAC   = 14;

  // plane sums: 12b normal times 36b vertex coord, three terms, plus offset
  localparam int PW = 52;

  typedef struct packed {
    logic signed [11:0] a;
    logic signed [11:0] b;
    logic signed [11:0] c;
    logic signed [27:0] d;
  } plane_t;

  // item travelling down the plane cells
  typedef struct packed {
    logic              box;
    logic              done;
    logic [1:0]        verdict;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic signed [22:0] ex;
    logic signed [22:0] ey;
    logic signed [22:0] ez;
    logic [19:0]       rad;
  } cell_item_t;

  function automatic plane_t unpack_plane(input logic [63:0] r);
    plane_t p;
    p.a = r[11:0];
    p.b = r[23:12];
    p.c = r[35:24];
    p.d = r[63:36];
    return p;
  endfunction

endpackage
`default_nettype wire

[design/frustum_cull_test.sv]
// registered stages from input accept to verdict valid: entry, depth, four plane cells
// throughput: one item per cycle when not stalled; each plane cell holds one item in flight
// the whole pipeline stalls when a valid output is not taken
// reset: synchronous, clears valid bits and loads register defaults
// (planes zero, view (0,1,0), max depth 400.0, origin and home sector zero)
`default_nettype none
module frustum_cull_test #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int SECTOR_SHIFT    = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic signed [20:0] first_x,
  input  wire logic signed [20:0] first_y,
  input  wire logic signed [20:0] first_z,
  input  wire logic signed [20:0] second_x,
  input  wire logic signed [20:0] second_y,
  input  wire logic signed [20:0] second_z,
  input  wire logic [19:0]        radius,
  input  wire logic signed [7:0]  sector_x,
  input  wire logic signed [7:0]  sector_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              verdict,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  localparam int UNIT_SHIFT = SECTOR_SHIFT + COORD_FRAC_BITS + 1;

  // configuration registers
  logic [63:0] planes [fct_pkg::NUM_PLANES];
  logic [47:0] view_direction;
  logic [62:0] view_origin;
  logic [19:0] max_depth;
  logic [15:0] home_sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fct_pkg::NUM_PLANES; i++) planes[i] <= '0;
      view_direction <= 48'h0000_4000_0000;
      view_origin <= '0;
      max_depth <= 20'd102400;
      home_sector <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fct_pkg::REG_PLANE_LEFT:   planes[0] <= cfg_data;
        fct_pkg::REG_PLANE_RIGHT:  planes[1] <= cfg_data;
        fct_pkg::REG_PLANE_TOP:    planes[2] <= cfg_data;
        fct_pkg::REG_PLANE_BOTTOM: planes[3] <= cfg_data;
        fct_pkg::REG_VIEW_DIR:     view_direction <= cfg_data[47:0];
        fct_pkg::REG_VIEW_ORIGIN:  view_origin <= cfg_data[62:0];
        fct_pkg::REG_MAX_DEPTH:    max_depth <= cfg_data[19:0];
        fct_pkg::REG_HOME_SECTOR:  home_sector <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] dir [3];
  logic signed [20:0] org [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir[k] = view_direction[16*k +: 16];
      org[k] = view_origin[21*k +: 21];
    end
  end

  // global stall: pipeline moves when the output slot is free or taken
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: boxes get doubled centre, extent and origin offset; spheres keep plain centre
  logic s0_valid;
  fct_pkg::cell_item_t s0;
  logic signed [34:0] s0_rel [3];
  logic signed [8:0] dsx, dsy;
  logic signed [34:0] shx, shy;
  assign dsx = 9'(sector_x) - 9'($signed(home_sector[7:0]));
  assign dsy = 9'(sector_y) - 9'($signed(home_sector[15:8]));
  assign shx = 35'(dsx) <<< UNIT_SHIFT;
  assign shy = 35'(dsy) <<< UNIT_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= in_valid;
    if (en) begin
      s0.box <= opcode;
      s0.done <= 1'b0;
      s0.verdict <= opcode ? fct_pkg::VERDICT_INTERSECT : fct_pkg::VERDICT_IN;
      s0.rad <= radius;
      if (opcode) begin
        s0.cx <= 34'(35'(first_x) + 35'(second_x) + shx);
        s0.cy <= 34'(35'(first_y) + 35'(second_y) + shy);
        s0.cz <= 34'(35'(first_z) + 35'(second_z));
        s0.ex <= 23'(second_x) - 23'(first_x);
        s0.ey <= 23'(second_y) - 23'(first_y);
        s0.ez <= 23'(second_z) - 23'(first_z);
        s0_rel[0] <= 35'(first_x) + 35'(second_x) + shx - (35'(org[0]) <<< 1);
        s0_rel[1] <= 35'(first_y) + 35'(second_y) + shy - (35'(org[1]) <<< 1);
        s0_rel[2] <= 35'(first_z) + 35'(second_z) - (35'(org[2]) <<< 1);
      end else begin
        s0.cx <= 34'(first_x);
        s0.cy <= 34'(first_y);
        s0.cz <= 34'(first_z);
        s0.ex <= '0;
        s0.ey <= '0;
        s0.ez <= '0;
        s0_rel[0] <= 35'(first_x) - 35'(org[0]);
        s0_rel[1] <= 35'(first_y) - 35'(org[1]);
        s0_rel[2] <= 35'(first_z) - 35'(org[2]);
      end
    end
  end

  // stage 1: depth slab test
  logic signed [55:0] dnear, dfar, dt_near [3], dt_far [3];
  logic signed [55:0] maxz, rz;
  logic s1_valid;
  fct_pkg::cell_item_t s1, s1_next;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [36:0] en_v, ef_v;
      en_v = 37'(s0_rel[k]);
      ef_v = 37'(s0_rel[k]);
      if (s0.box && dir[k] > 0) begin
        en_v = en_v + 37'(k == 0 ? s0.ex : (k == 1 ? s0.ey : s0.ez));
        ef_v = ef_v - 37'(k == 0 ? s0.ex : (k == 1 ? s0.ey : s0.ez));
      end else if (s0.box && dir[k] < 0) begin
        en_v = en_v - 37'(k == 0 ? s0.ex : (k == 1 ? s0.ey : s0.ez));
        ef_v = ef_v + 37'(k == 0 ? s0.ex : (k == 1 ? s0.ey : s0.ez));
      end
      dt_near[k] = 56'(dir[k] * en_v);
      dt_far[k] = 56'(dir[k] * ef_v);
    end
    dnear = dt_near[0] + dt_near[1] + dt_near[2];
    dfar = dt_far[0] + dt_far[1] + dt_far[2];
    maxz = 56'({1'b0, max_depth}) <<< fct_pkg::DIR_FRAC;
    rz = 56'({1'b0, s0.rad}) <<< fct_pkg::DIR_FRAC;
    s1_next = s0;
    if (s0.box) begin
      if (dnear < 0 || dfar > (maxz <<< 1)) begin
        s1_next.done = 1'b1;
        s1_next.verdict = fct_pkg::VERDICT_OUT;
      end
    end else if (dnear < -rz || dnear > maxz + rz) begin
      s1_next.done = 1'b1;
      s1_next.verdict = fct_pkg::VERDICT_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s0_valid;
    if (en) s1 <= s1_next;
  end

  // chain of plane cells
  logic cv [fct_pkg::NUM_PLANES+1];
  fct_pkg::cell_item_t ci [fct_pkg::NUM_PLANES+1];
  assign cv[0] = s1_valid;
  assign ci[0] = s1;

  for (genvar g = 0; g < fct_pkg::NUM_PLANES; g++) begin : g_cell
    fct_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[g]), .in_item(ci[g]),
      .plane(fct_pkg::unpack_plane(planes[g])),
      .out_valid(cv[g+1]), .out_item(ci[g+1])
    );
  end

  assign out_valid = cv[fct_pkg::NUM_PLANES];
  assign verdict = ci[fct_pkg::NUM_PLANES].verdict;

  // checks
  a_box_never_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && ci[fct_pkg::NUM_PLANES].box |-> verdict != fct_pkg::VERDICT_IN)
    else $error("box item reported fully inside");
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict != 2'd3)
    else $error("bad verdict code");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("result changed under stall");

endmodule
`default_nettype wire

[design/fct_cell.sv]
`default_nettype none
module fct_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire fct_pkg::cell_item_t   in_item,
  input  wire fct_pkg::plane_t       plane,
  output logic                       out_valid,
  output fct_pkg::cell_item_t        out_item
);

  logic signed [fct_pkg::PW-1:0] tx, ty, tz, dot, dterm, rp;
  fct_pkg::cell_item_t nxt;

  // positive vertex term per axis (box), plain centre (sphere)
  function automatic logic signed [fct_pkg::PW-1:0] vtx(
    input logic signed [11:0] n, input logic signed [33:0] c,
    input logic signed [22:0] e, input logic box);
    logic signed [35:0] v;
    v = 36'(c);
    if (box && n > 0) v = v + 36'(e);
    if (box && n < 0) v = v - 36'(e);
    return fct_pkg::PW'(n * v);
  endfunction

  assign tx = vtx(plane.a, in_item.cx, in_item.ex, in_item.box);
  assign ty = vtx(plane.b, in_item.cy, in_item.ey, in_item.box);
  assign tz = vtx(plane.c, in_item.cz, in_item.ez, in_item.box);
  assign dot = tx + ty + tz;
  assign dterm = fct_pkg::PW'(plane.d) <<< fct_pkg::NORM_FRAC;
  assign rp = fct_pkg::PW'({1'b0, in_item.rad}) <<< fct_pkg::NORM_FRAC;

  // plane decision
  always_comb begin
    nxt = in_item;
    if (!in_item.done) begin
      if (in_item.box) begin
        if (dot < -(dterm <<< 1)) begin
          nxt.verdict = fct_pkg::VERDICT_OUT;
          nxt.done = 1'b1;
        end
      end else begin
        if (dot + dterm < -rp) begin
          nxt.verdict = fct_pkg::VERDICT_OUT;
          nxt.done = 1'b1;
        end else if (dot + dterm < rp && dot + dterm > -rp) begin
          nxt.verdict = fct_pkg::VERDICT_INTERSECT;
          nxt.done = 1'b1;
        end
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) out_item <= nxt;
  end

endmodule
`default_nettype wire
